// File: rtl/fbm_pkg.sv
`timescale 1ns / 1ps

package fbm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 15;
    localparam int TAPCNT_W   = 9;
    localparam int TAPIDX_W   = 9;
    localparam int BORDER_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int MIN_TAPS   = 9;
    localparam int RESET_TAPS = 257;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE = 8'd1;

    localparam logic [BORDER_W-1:0] BORDER_FULL   = 2'd0;
    localparam logic [BORDER_W-1:0] BORDER_HALF   = 2'd1;
    localparam logic [BORDER_W-1:0] BORDER_NONE   = 2'd2;
    localparam logic [BORDER_W-1:0] BORDER_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_RESET  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctrl;

endpackage

// File: rtl/fbm_ram.sv
`timescale 1ns / 1ps

module fbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fbm_mac.sv
`timescale 1ns / 1ps

module fbm_mac import fbm_pkg::*; #(
    parameter int ACC_W = 41
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctrl                  i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_a,
    input  logic signed [SAMPLE_W-1:0] i_b,
    output logic                       o_busy,
    output logic signed [SAMPLE_W-1:0] o_result
);

    localparam int QW = ACC_W - FRAC_W;

    logic signed [2*SAMPLE_W-1:0] r_prod;
    logic                         r_prod_v;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      biased;
    logic signed [QW-1:0]         quot;
    logic [QW-SAMPLE_W:0]         upper;
    logic                         ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctrl.en;
        end
        if (i_ctrl.en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign biased = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
    assign quot   = biased[ACC_W-1:FRAC_W];
    assign upper  = quot[QW-1:SAMPLE_W-1];
    assign ovf    = !((&upper) || !(|upper));

    always_comb begin
        if (ovf) begin
            o_result = quot[QW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            o_result = quot[SAMPLE_W-1:0];
        end
    end

    assign o_busy = r_prod_v;

endmodule

// File: rtl/fir_filter_border_modes_unit.sv
`timescale 1ns / 1ps

// Odd-length direct-form FIR with border handling, one shared multiply-accumulate.
// Input channel (i_in_valid / o_in_ready) carries a command with its operands:
// coefficient load, sample, flush of one zero, or run reset. The output channel
// (o_out_valid / i_out_ready) carries the filtered sample and the last-of-run flag.
// Configuration port (i_cfg_valid / o_cfg_ready) writes tap count (index 0) and
// border mode (index 1); a write to either restarts the run.
// A coefficient load is written straight into the coefficient RAM. For a sample or
// flush, the MAC steps through one coefficient and one delay entry per cycle, for n
// entries, n the effective tap count; then the product register, accumulator and
// result stages drain. A new request is taken only once the last one is done.
// Reset, a run reset command and each tap count or border mode write start a
// clearing pass over the MAX_TAPS - 1 delay line entries (256 at the default),
// during which no request is taken; the counters then reload from the registers.
// A result waits in the output register while the receiver stalls; the next
// request is still taken, and only its final stage waits for the register.
module fir_filter_border_modes_unit import fbm_pkg::*; #(
    parameter int MAX_TAPS = 257
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_command,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [TAPIDX_W-1:0]        i_tap_index,
    input  logic signed [SAMPLE_W-1:0] i_tap_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_filtered_sample,
    output logic                       o_is_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW      = $clog2(MAX_TAPS);
    localparam int DEPTH_D = MAX_TAPS - 1;
    localparam int DW      = $clog2(DEPTH_D);
    localparam int NW      = $clog2(MAX_TAPS + 1);
    localparam int ACC_W   = 2 * SAMPLE_W + $clog2(MAX_TAPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state                      r_state;
    logic [TAPCNT_W-1:0]         r_tap_count;
    logic [BORDER_W-1:0]         r_border;
    logic [DW-1:0]               r_wslot;
    logic [DW-1:0]               r_wslot_old;
    logic [NW-1:0]               r_prefill;
    logic [NW-1:0]               r_flush;
    logic                        r_finished;
    logic [DW-1:0]               r_clr_cnt;
    logic [CW-1:0]               r_k;
    logic [DW-1:0]               r_pos;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic                        r_emit;
    logic                        r_last;
    logic                        r_issue_v;
    logic                        r_issue_first;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_sample;
    logic                        r_out_last;

    logic [31:0]                 tc_odd;
    logic [NW-1:0]               eff_taps;
    logic [NW-1:0]               tap_len;
    logic [NW-1:0]               ws_ext;
    logic [NW-1:0]               ws_inc;
    logic [DW-1:0]               base_pos;
    logic [DW-1:0]               ws_next;
    logic [NW-1:0]               pos_inc;
    logic [DW-1:0]               pos_step;
    logic                        in_acc;
    logic                        start_push;
    logic                        push_emit;
    logic                        push_last;
    logic signed [SAMPLE_W-1:0]  push_x;
    logic                        pipe_empty;

    logic                        coef_we;
    logic [CW-1:0]               coef_waddr;
    logic [SAMPLE_W-1:0]         coef_rdata;
    logic                        dl_we;
    logic [DW-1:0]               dl_waddr;
    logic [SAMPLE_W-1:0]         dl_wdata;
    logic [SAMPLE_W-1:0]         dl_rdata;

    t_mac_ctrl                   mac_ctrl;
    logic signed [SAMPLE_W-1:0]  mac_a;
    logic                        mac_busy;
    logic signed [SAMPLE_W-1:0]  mac_result;

    assign tc_odd   = 32'(r_tap_count) | 32'd1;
    assign eff_taps = (tc_odd < 32'(MIN_TAPS) || tc_odd > 32'(MAX_TAPS))
                      ? NW'(MAX_TAPS) : NW'(tc_odd);
    assign tap_len  = eff_taps - NW'(1);

    assign ws_ext   = NW'(r_wslot);
    assign ws_inc   = ws_ext + NW'(1);
    assign base_pos = (ws_inc >= tap_len) ? '0 : DW'(ws_inc);
    assign ws_next  = (r_wslot == '0 || ws_ext >= tap_len) ? DW'(tap_len - NW'(1))
                                                          : r_wslot - DW'(1);
    assign pos_inc  = NW'(r_pos) + NW'(1);
    assign pos_step = (pos_inc == tap_len) ? '0 : DW'(pos_inc);

    assign in_acc     = i_in_valid && o_in_ready;
    assign pipe_empty = !r_issue_v && !mac_busy;

    always_comb begin
        start_push = 1'b0;
        push_emit  = 1'b0;
        push_last  = 1'b0;
        push_x     = '0;
        case (t_cmd'(i_command))
            CMD_SAMPLE: begin
                start_push = in_acc && !r_finished;
                push_emit  = (r_prefill == '0);
                push_x     = i_sample;
            end
            CMD_FLUSH: begin
                start_push = in_acc && !r_finished && (r_flush != '0);
                push_emit  = 1'b1;
                push_last  = (r_flush == NW'(1));
            end
            default: begin
                start_push = 1'b0;
            end
        endcase
    end

    assign coef_we    = in_acc && (t_cmd'(i_command) == CMD_LOAD)
                        && (32'(i_tap_index) < 32'(MAX_TAPS));
    assign coef_waddr = CW'(i_tap_index);

    assign dl_we    = (r_state == ST_CLEAR) || (r_state == ST_DRAIN && pipe_empty);
    assign dl_waddr = (r_state == ST_CLEAR) ? r_clr_cnt : r_wslot_old;
    assign dl_wdata = (r_state == ST_CLEAR) ? '0 : r_x;

    assign mac_ctrl.clr = start_push;
    assign mac_ctrl.en  = r_issue_v;
    assign mac_a        = r_issue_first ? r_x : $signed(dl_rdata);

    fbm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_tap_value),
        .i_raddr (r_k),
        .o_rdata (coef_rdata)
    );

    fbm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH_D)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (r_pos),
        .o_rdata (dl_rdata)
    );

    fbm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_a      (mac_a),
        .i_b      ($signed(coef_rdata)),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_tap_count   <= TAPCNT_W'(RESET_TAPS);
            r_border      <= BORDER_FULL;
            r_wslot       <= '0;
            r_prefill     <= '0;
            r_flush       <= '0;
            r_finished    <= 1'b0;
            r_clr_cnt     <= '0;
            r_k           <= '0;
            r_pos         <= '0;
            r_issue_v     <= 1'b0;
            r_issue_first <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_issue_v <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && t_cmd'(i_command) == CMD_RESET) begin
                        r_state   <= ST_CLEAR;
                        r_clr_cnt <= '0;
                    end
                    if (start_push) begin
                        r_state     <= ST_MAC;
                        r_x         <= push_x;
                        r_emit      <= push_emit;
                        r_last      <= push_last;
                        r_k         <= '0;
                        r_pos       <= base_pos;
                        r_wslot_old <= r_wslot;
                        r_wslot     <= ws_next;
                        if (t_cmd'(i_command) == CMD_SAMPLE) begin
                            if (r_prefill != '0) begin
                                r_prefill <= r_prefill - NW'(1);
                            end
                        end else begin
                            r_flush <= r_flush - NW'(1);
                            if (push_last) begin
                                r_finished <= 1'b1;
                            end
                        end
                    end
                end
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + DW'(1);
                    if (r_clr_cnt == DW'(DEPTH_D - 1)) begin
                        r_state    <= ST_IDLE;
                        r_wslot    <= DW'(eff_taps - NW'(2));
                        r_finished <= 1'b0;
                        case (r_border)
                            BORDER_FULL: begin
                                r_prefill <= tap_len;
                                r_flush   <= '0;
                            end
                            BORDER_HALF: begin
                                r_prefill <= eff_taps >> 1;
                                r_flush   <= eff_taps >> 1;
                            end
                            default: begin
                                r_prefill <= '0;
                                r_flush   <= '0;
                            end
                        endcase
                    end
                end
                ST_MAC: begin
                    r_issue_v     <= 1'b1;
                    r_issue_first <= (r_k == '0);
                    r_k           <= r_k + CW'(1);
                    if (r_k != '0) begin
                        r_pos <= pos_step;
                    end
                    if (NW'(r_k) == tap_len) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        r_res   <= mac_result;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_emit) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res;
                        r_out_last   <= r_last;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TAP_COUNT: begin
                        r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                        r_state     <= ST_CLEAR;
                        r_clr_cnt   <= '0;
                    end
                    CFG_BORDER_MODE: begin
                        r_border  <= (i_cfg_data[BORDER_W-1:0] == BORDER_UNUSED)
                                     ? BORDER_NONE : i_cfg_data[BORDER_W-1:0];
                        r_state   <= ST_CLEAR;
                        r_clr_cnt <= '0;
                    end
                    default: begin
                        r_border <= r_border;
                    end
                endcase
            end
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_is_last         = r_out_last;

    a_pos_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (NW'(r_pos) < tap_len))
        else $error("delay read address beyond the line");

    a_wslot_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (ws_ext < tap_len))
        else $error("write slot beyond the line");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the final stage");

    a_finished_no_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_flush == '0))
        else $error("run finished with flush outputs left");

endmodule
